@@ hdl/packet_header_filter_macros.svh @@
// Assertion helpers for the packet header filter checker.
// Both sample on clk and stay quiet while rst_n is low.
`ifndef PACKET_HEADER_FILTER_MACROS_SVH
`define PACKET_HEADER_FILTER_MACROS_SVH

// Same-cycle implication.
`define PHF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PHF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/phf_pkg.sv @@
package phf_pkg;

  localparam logic [12:0] HDR_BYTES = 13'd8;
  localparam logic [3:0]  TYPE_A    = 4'h4;
  localparam logic [3:0]  TYPE_B    = 4'h6;

  // header byte positions
  localparam logic [12:0] POS_DEST = 13'd2;
  localparam logic [12:0] POS_TYPE = 13'd4;
  localparam logic [12:0] POS_LENH = 13'd6;
  localparam logic [12:0] POS_LENL = 13'd7;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SMALL = 2'd1,
    ST_LEN   = 2'd2,
    ST_TYPE  = 2'd3
  } status_t;

  // one queued action: a payload result, a status result, or both
  typedef struct packed {
    logic        has_pay;
    logic        has_stat;
    logic [7:0]  pay_byte;
    logic        pay_end;
    logic [31:0] meta;
    status_t     status;
  } qent_t;

  function automatic logic [31:0] pack_meta(input logic [11:0] plen, input logic [3:0] typ,
                                            input logic [7:0] dst, input logic [7:0] src);
    return {src, dst, typ, plen};
  endfunction

endpackage

@@ hdl/phf_front.sv @@
module phf_front
  import phf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  byte_value,
  input  logic [12:0] packet_bytes,
  input  logic        end_of_packet,
  input  logic        q_full,
  output logic        q_push,
  output qent_t       q_wdata
);

  typedef enum logic [1:0] {
    PH_IDLE, PH_HEADER, PH_PAYLOAD, PH_DISCARD
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [12:0] idx_r, idx_nxt;
  logic [12:0] size_r, size_nxt;
  logic [7:0]  src_r, src_nxt;
  logic [7:0]  dst_r, dst_nxt;
  logic [3:0]  typ_r, typ_nxt;
  logic [7:0]  lenh_r, lenh_nxt;
  logic [11:0] plen_r, plen_nxt;
  status_t     drop_r, drop_nxt;
  logic [11:0] plen_w;
  logic        last;
  logic        acc;

  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;
  assign plen_w    = {lenh_r[3:0], byte_value};

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    size_nxt  = size_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    typ_nxt   = typ_r;
    lenh_nxt  = lenh_r;
    plen_nxt  = plen_r;
    drop_nxt  = drop_r;
    last      = 1'b0;
    q_wdata   = '0;

    unique case (phase_r)
      PH_IDLE: begin
        size_nxt = packet_bytes;
        idx_nxt  = '0;
        src_nxt  = '0;
        dst_nxt  = '0;
        typ_nxt  = '0;
        lenh_nxt = '0;
        plen_nxt = '0;
        if (packet_bytes < HDR_BYTES) begin
          drop_nxt  = ST_SMALL;
          phase_nxt = PH_DISCARD;
        end else begin
          drop_nxt  = ST_OK;
          src_nxt   = byte_value;
          phase_nxt = PH_HEADER;
        end
      end
      PH_HEADER: begin
        idx_nxt = idx_r + 13'd1;
        unique case (idx_nxt)
          POS_DEST: dst_nxt  = byte_value;
          POS_TYPE: typ_nxt  = byte_value[3:0];
          POS_LENH: lenh_nxt = byte_value;
          POS_LENL: begin
            plen_nxt = plen_w;
            if ({1'b0, plen_w} + HDR_BYTES > size_r) begin
              drop_nxt  = ST_LEN;
              phase_nxt = PH_DISCARD;
            end else if (typ_r != TYPE_A && typ_r != TYPE_B) begin
              drop_nxt  = ST_TYPE;
              phase_nxt = PH_DISCARD;
            end else begin
              drop_nxt  = ST_OK;
              phase_nxt = (plen_w != 12'd0) ? PH_PAYLOAD : PH_DISCARD;
            end
          end
          default: ;
        endcase
      end
      PH_PAYLOAD: begin
        idx_nxt          = idx_r + 13'd1;
        last             = (idx_nxt == {1'b0, plen_r} + HDR_BYTES - 13'd1);
        q_wdata.has_pay  = 1'b1;
        q_wdata.pay_byte = byte_value;
        q_wdata.pay_end  = last || end_of_packet;
        if (last) phase_nxt = PH_DISCARD;
      end
      PH_DISCARD: ;
      default: ;
    endcase

    if (end_of_packet) begin
      // packet closed before the header finished
      if (phase_nxt == PH_HEADER) drop_nxt = ST_SMALL;
      q_wdata.has_stat = 1'b1;
      q_wdata.status   = drop_nxt;
      phase_nxt        = PH_IDLE;
    end

    q_wdata.meta = (q_wdata.has_stat && drop_nxt == ST_SMALL) ? 32'd0 :
                   pack_meta(plen_nxt, typ_nxt, dst_nxt, src_nxt);
  end

  assign q_push = acc && (q_wdata.has_pay || q_wdata.has_stat);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      idx_r   <= '0;
      size_r  <= '0;
      src_r   <= '0;
      dst_r   <= '0;
      typ_r   <= '0;
      lenh_r  <= '0;
      plen_r  <= '0;
      drop_r  <= ST_OK;
    end else if (acc) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      size_r  <= size_nxt;
      src_r   <= src_nxt;
      dst_r   <= dst_nxt;
      typ_r   <= typ_nxt;
      lenh_r  <= lenh_nxt;
      plen_r  <= plen_nxt;
      drop_r  <= drop_nxt;
    end
  end

endmodule

@@ hdl/phf_queue.sv @@
module phf_queue
  import phf_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  qent_t wdata,
  input  logic  pop,
  output qent_t head,
  output logic  empty,
  output logic  full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  qent_t         mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == FULL_CNT);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
      if (do_push && !do_pop)      cnt_r <= cnt_r + CW'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - CW'(1);
    end
  end

endmodule

@@ hdl/phf_back.sv @@
module phf_back
  import phf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  qent_t       head,
  input  logic        q_empty,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic        kind,
  output logic [7:0]  payload_byte,
  output logic        payload_end,
  output logic [31:0] meta_word,
  output status_t     status
);

  logic        valid_r, valid_nxt;
  logic        paydone_r, paydone_nxt;
  logic        kind_r, kind_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        end_r, end_nxt;
  logic [31:0] meta_r, meta_nxt;
  status_t     stat_r, stat_nxt;
  logic        load;

  assign load = !q_empty && (!valid_r || out_tready);

  always_comb begin
    valid_nxt   = valid_r;
    paydone_nxt = paydone_r;
    kind_nxt    = kind_r;
    byte_nxt    = byte_r;
    end_nxt     = end_r;
    meta_nxt    = meta_r;
    stat_nxt    = stat_r;
    q_pop       = 1'b0;
    if (valid_r && out_tready) valid_nxt = 1'b0;
    if (load) begin
      valid_nxt = 1'b1;
      meta_nxt  = head.meta;
      if (head.has_pay && !paydone_r) begin
        kind_nxt = 1'b0;
        byte_nxt = head.pay_byte;
        end_nxt  = head.pay_end;
        stat_nxt = ST_OK;
        // hold the entry when its status still has to follow
        if (head.has_stat) paydone_nxt = 1'b1;
        else q_pop = 1'b1;
      end else begin
        kind_nxt    = 1'b1;
        byte_nxt    = 8'd0;
        end_nxt     = 1'b0;
        stat_nxt    = head.status;
        paydone_nxt = 1'b0;
        q_pop       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      paydone_r <= 1'b0;
    end else begin
      valid_r   <= valid_nxt;
      paydone_r <= paydone_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    byte_r <= byte_nxt;
    end_r  <= end_nxt;
    meta_r <= meta_nxt;
    stat_r <= stat_nxt;
  end

  assign out_tvalid   = valid_r;
  assign kind         = kind_r;
  assign payload_byte = byte_r;
  assign payload_end  = end_r;
  assign meta_word    = meta_r;
  assign status       = stat_r;

endmodule

@@ hdl/packet_header_filter.sv @@
// Packet header filter.
// Input stream: one packet byte per transfer. in_tlast marks the last byte
// of a packet; the total packet size rides in in_tdata and is sampled on
// the first byte only.
// Output stream: forwarded payload bytes (out_tuser = 0, out_tlast on the
// last forwarded byte) and one status result per packet (out_tuser = 1),
// issued on the byte that carries in_tlast, after that byte's payload
// result if it has one. Every result carries the packed header word,
// except the status of a packet that is too short, which carries zero.
// Throughput: one input byte per cycle while the queue has room. A byte that
// yields both a payload and a status result needs two output transfers; a
// QDEPTH-entry queue between the parser and the output stage absorbs that.
// A byte is written into the queue, then loaded into the output register,
// raising out_tvalid, if the queue was empty and that register free or taken.
// A receiver stall holds the output register; the parser keeps taking bytes
// until the queue fills, then drops in_tready.
// Reset (rst_n low, synchronous) empties the queue, clears the output valid
// and returns the parser to waiting for a packet's first byte.
module packet_header_filter
  import phf_pkg::*;
#(
  parameter int QDEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // byte_value[7:0], packet_bytes[20:8], zero pad
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // payload_byte[7:0], meta_word[39:8], status[41:40], pad
  output logic [0:0]  out_tuser,  // kind[0]
  output logic        out_tlast
);

  qent_t       q_wdata, q_head;
  logic        q_push, q_pop, q_empty, q_full;
  logic        kind;
  logic [7:0]  payload_byte;
  logic [31:0] meta_word;
  status_t     status;

  phf_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .byte_value    (in_tdata[7:0]),
    .packet_bytes  (in_tdata[20:8]),
    .end_of_packet (in_tlast),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_wdata       (q_wdata)
  );

  phf_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .head  (q_head),
    .empty (q_empty),
    .full  (q_full)
  );

  phf_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (q_head),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .kind         (kind),
    .payload_byte (payload_byte),
    .payload_end  (out_tlast),
    .meta_word    (meta_word),
    .status       (status)
  );

  assign out_tdata = {6'd0, status, meta_word, payload_byte};
  assign out_tuser = kind;

endmodule

@@ hdl/phf_checker.sv @@
`include "packet_header_filter_macros.svh"

module phf_checker
  import phf_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [0:0]  out_tuser,
  input logic        out_tlast
);

  `PHF_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "stalled result changed")
  `PHF_ASSERT_NOW(a_status_clean, out_tvalid && out_tuser[0], out_tdata[7:0] == 8'd0 && !out_tlast, "status result carries payload")
  `PHF_ASSERT_NOW(a_payload_ok, out_tvalid && !out_tuser[0], out_tdata[41:40] == ST_OK, "payload result with nonzero status")
  `PHF_ASSERT_NOW(a_small_meta, out_tvalid && out_tuser[0] && out_tdata[41:40] == ST_SMALL, out_tdata[39:8] == 32'd0, "short packet status with header word")

endmodule

bind packet_header_filter phf_checker u_phf_checker (.*);

@@ tb/sv/packet_header_filter_checker.sv @@
`timescale 1ns / 1ps

module packet_header_filter_checker
  import phf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // byte_value[7:0], packet_bytes[20:8], zero pad
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,  // payload_byte[7:0], meta_word[39:8], status[41:40], pad
  input  logic [0:0]  out_tuser,  // kind[0]
  input  logic        out_tlast,
  input  logic        run_done,
  output int          fail_count,
  output int          outstanding
);

  typedef enum logic [1:0] {
    PARSE_IDLE    = 2'd0,
    PARSE_HEADER  = 2'd1,
    PARSE_PAYLOAD = 2'd2,
    PARSE_DISCARD = 2'd3
  } parse_phase_t;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  pay;
    logic        pay_end;
    logic [31:0] meta;
    status_t     status;
  } filt_result_t;

  filt_result_t filt_result_q[$];

  parse_phase_t phase_r;
  logic [12:0]  idx_r;
  logic [12:0]  size_r;
  logic [7:0]   src_r;
  logic [7:0]   dst_r;
  logic [3:0]   typ_r;
  logic [7:0]   len_hi_r;
  logic [11:0]  len_r;
  status_t      verdict_r;
  bit           leftovers_flagged;

  function automatic logic [31:0] header_word();
    return {src_r, dst_r, typ_r, len_r};
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: %s", $realtime, what);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s mismatch: got 0x%0h, want 0x%0h", name, got, want));
  endtask

  task automatic clear_parser();
    idx_r    = '0;
    src_r    = '0;
    dst_r    = '0;
    typ_r    = '0;
    len_hi_r = '0;
    len_r    = '0;
  endtask

  task automatic filter_byte(input logic [7:0] b, input logic [12:0] sz, input logic eop);
    logic         last;
    filt_result_t r;
    case (phase_r)
      PARSE_IDLE: begin
        clear_parser();
        size_r = sz;
        if (sz < HDR_BYTES) begin
          verdict_r = ST_SMALL;
          phase_r   = PARSE_DISCARD;
        end else begin
          verdict_r = ST_OK;
          src_r     = b;
          phase_r   = PARSE_HEADER;
        end
      end
      PARSE_HEADER: begin
        idx_r = idx_r + 13'd1;
        if (idx_r == POS_DEST) begin
          dst_r = b;
        end else if (idx_r == POS_TYPE) begin
          typ_r = b[3:0];
        end else if (idx_r == POS_LENH) begin
          len_hi_r = b;
        end else if (idx_r == POS_LENL) begin
          len_r = {len_hi_r[3:0], b};
          if (len_r + HDR_BYTES > size_r) begin
            verdict_r = ST_LEN;
            phase_r   = PARSE_DISCARD;
          end else if (typ_r != TYPE_A && typ_r != TYPE_B) begin
            verdict_r = ST_TYPE;
            phase_r   = PARSE_DISCARD;
          end else begin
            verdict_r = ST_OK;
            phase_r   = (len_r != '0) ? PARSE_PAYLOAD : PARSE_DISCARD;
          end
        end
      end
      PARSE_PAYLOAD: begin
        idx_r     = idx_r + 13'd1;
        last      = (idx_r == len_r + HDR_BYTES - 13'd1);
        r.kind    = KIND_PAYLOAD;
        r.pay     = b;
        r.pay_end = last | eop;
        r.meta    = header_word();
        r.status  = ST_OK;
        filt_result_q.push_back(r);
        if (last)
          phase_r = PARSE_DISCARD;
      end
      default: ;
    endcase

    // the byte with tlast always closes the packet with a status
    if (eop) begin
      if (phase_r == PARSE_HEADER)
        verdict_r = ST_SMALL;
      r.kind    = KIND_STATUS;
      r.pay     = '0;
      r.pay_end = 1'b0;
      r.meta    = (verdict_r == ST_SMALL) ? '0 : header_word();
      r.status  = verdict_r;
      filt_result_q.push_back(r);
      phase_r = PARSE_IDLE;
    end
  endtask

  always @(posedge clk) begin
    filt_result_t want;
    if (!rst_n) begin
      phase_r   = PARSE_IDLE;
      size_r    = '0;
      verdict_r = ST_OK;
      clear_parser();
      filt_result_q.delete();
    end else begin
      if (in_tvalid && in_tready)
        filter_byte(in_tdata[7:0], in_tdata[20:8], in_tlast);

      if (out_tvalid && out_tready) begin
        if (filt_result_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result transfer: tuser %0d tdata 0x%0h",
                                    out_tuser, out_tdata));
        end else begin
          want = filt_result_q.pop_front();
          check_field("kind", 32'(out_tuser[0]), 32'(want.kind));
          check_field("payload_byte", 32'(out_tdata[7:0]), 32'(want.pay));
          check_field("payload_end", 32'(out_tlast), 32'(want.pay_end));
          check_field("meta_word", out_tdata[39:8], want.meta);
          check_field("status", 32'(out_tdata[41:40]), 32'(want.status));
        end
      end

      if (run_done && !leftovers_flagged) begin
        leftovers_flagged = 1'b1;
        foreach (filt_result_q[i])
          report_mismatch($sformatf("result never arrived: kind %0d byte 0x%0h status %0d",
                                    filt_result_q[i].kind, filt_result_q[i].pay,
                                    filt_result_q[i].status));
      end
    end
    outstanding <= filt_result_q.size();
  end

endmodule

@@ tb/sv/packet_header_filter_tb.sv @@
`timescale 1ns / 1ps

module packet_header_filter_tb;
  import phf_pkg::*;

  localparam int RANDOM_BYTES  = 450;
  localparam int QUIET_BYTES   = 380;
  localparam int HOLD_CYCLES   = 300;
  localparam int HOLD_PACKET   = 4;
  localparam int PAUSE_PACKET  = 12;
  localparam int DRAIN_LIMIT   = 4000;
  localparam int TAIL_CYCLES   = 20;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // byte_value[7:0], packet_bytes[20:8], zero pad
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // payload_byte[7:0], meta_word[39:8], status[41:40], pad
  logic [0:0]  out_tuser;  // kind[0]
  logic        out_tlast;

  logic        quiet;
  logic        hold_req;
  logic        run_done;
  bit          no_gap;
  int          fail_count;
  int          outstanding;

  always #2 clk = ~clk;

  packet_header_filter i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  packet_header_filter_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .run_done    (run_done),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // offer one byte and hold it until the transfer, then maybe idle
  task automatic xmit_byte(input logic [7:0] b, input logic [12:0] sz, input logic eop);
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, sz, b};
    in_tlast  <= eop;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (!quiet && !no_gap && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic send_packet(input logic [7:0] pkt[$], input logic [12:0] declared);
    logic [12:0] junk;
    for (int i = 0; i < pkt.size(); i++) begin
      junk = 13'($urandom);
      xmit_byte(pkt[i], (i == 0) ? declared : junk, i == pkt.size() - 1);
    end
  endtask

  task automatic wait_results_drained(input int limit);
    int n;
    n = 0;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 && n < limit) begin
      @(posedge clk);
      n++;
    end
  endtask

  task automatic send_random_packet(output int nbytes);
    logic [7:0]  pkt[$];
    logic [7:0]  hdr[8];
    logic [3:0]  typ;
    int          sel;
    int          plen;
    int          declared;
    bit          raw_len;
    sel     = $urandom_range(0, 99);
    raw_len = 1'b0;
    plen    = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
    typ     = $urandom_range(0, 1) ? TYPE_A : TYPE_B;
    nbytes  = plen + 8;
    declared = nbytes;
    if (sel < 55) begin
      // well-formed: vary declared size, trailing bytes and early end
      case ($urandom_range(0, 5))
        0: declared = $urandom_range(plen + 8, 8191);
        1: declared = plen + 8 + $urandom_range(1, 4);
        default: ;
      endcase
      if ($urandom_range(0, 3) == 0)
        nbytes = nbytes + $urandom_range(1, 3);
      else if (plen >= 2 && $urandom_range(0, 5) == 0)
        nbytes = $urandom_range(9, plen + 7);
    end else if (sel < 65) begin
      plen     = $urandom_range(1, 40);
      declared = $urandom_range(8, plen + 7);
      nbytes   = $urandom_range(8, plen + 10);
    end else if (sel < 75) begin
      do typ = 4'($urandom); while (typ == TYPE_A || typ == TYPE_B);
    end else if (sel < 83) begin
      declared = $urandom_range(0, 7);
      nbytes   = $urandom_range(1, 10);
    end else if (sel < 91) begin
      declared = $urandom_range(8, 8191);
      nbytes   = $urandom_range(1, 7);
    end else begin
      // noise: header and size fully random
      typ      = 4'($urandom);
      raw_len  = 1'b1;
      declared = $urandom_range(0, 8191);
      nbytes   = $urandom_range(1, 24);
    end

    foreach (hdr[i]) hdr[i] = 8'($urandom);
    hdr[POS_TYPE] = {hdr[POS_TYPE][7:4], typ};
    if (!raw_len) begin
      hdr[POS_LENH] = {hdr[POS_LENH][7:4], plen[11:8]};
      hdr[POS_LENL] = plen[7:0];
    end
    for (int i = 0; i < nbytes; i++)
      pkt.push_back((i < 8) ? hdr[i] : 8'($urandom));
    send_packet(pkt, 13'(declared));
  endtask

  initial begin
    logic [7:0] pkt[$];
    int         sent;
    int         n;
    int         pkt_count;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tlast  <= 1'b0;
    quiet     <= 1'b0;
    hold_req  <= 1'b0;
    run_done  <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // declared size zero, single byte
    pkt = {8'hFF};
    send_packet(pkt, 13'd0);
    // maximum size and length, type in low nibble only, ends inside payload
    pkt = {8'hFF, 8'h00, 8'h00, 8'h00, 8'hF4, 8'h00, 8'hFF, 8'hFF, 8'h00};
    send_packet(pkt, 13'd8191);
    // last payload byte also closes the packet
    pkt = {8'h12, 8'h34, 8'h56, 8'h78, 8'h06, 8'h9A, 8'h00, 8'h01, 8'hA5};
    send_packet(pkt, 13'd9);
    // packet ends inside the header
    pkt = {8'h01, 8'h02, 8'h03, 8'h04};
    send_packet(pkt, 13'd20);

    sent      = 0;
    pkt_count = 0;
    while (sent < RANDOM_BYTES) begin
      if (pkt_count == HOLD_PACKET)
        hold_req <= 1'b1;
      if (pkt_count == PAUSE_PACKET)
        wait_results_drained(DRAIN_LIMIT);
      if (sent >= QUIET_BYTES)
        quiet <= 1'b1;
      no_gap = ($urandom_range(0, 3) == 0);
      send_random_packet(n);
      sent += n;
      pkt_count++;
    end

    wait_results_drained(DRAIN_LIMIT);
    repeat (TAIL_CYCLES) @(posedge clk);
    run_done <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0)
      $display("packet_header_filter verification clean");
    else
      $display("packet_header_filter verification failed");
    $finish;
  end

  // result receiver: random stalls, one long hold-off on request
  initial begin
    bit hold_taken;
    hold_taken = 1'b0;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  initial begin
    #2000000;
    $display("packet_header_filter verification failed");
    $finish;
  end

endmodule

@@ packet_header_filter.f @@
+incdir+hdl
hdl/phf_pkg.sv
hdl/phf_front.sv
hdl/phf_queue.sv
hdl/phf_back.sv
hdl/packet_header_filter.sv
hdl/phf_checker.sv
tb/sv/packet_header_filter_checker.sv
tb/sv/packet_header_filter_tb.sv
